### sv/mag_occ_pkg.sv
`default_nettype none

package mag_occ_pkg;

    // sample geometry
    localparam int SAMPLE_W = 16;
    localparam int NUM_AXES = 3;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int DIST_W   = 34;
    localparam int DWELL_W  = 16;

    // baseline averaging
    localparam int CALIB_SAMPLES = 40;
    localparam int CNT_W         = $clog2(CALIB_SAMPLES + 1);
    localparam int SUM_W         = SAMPLE_W + CNT_W;

    // reciprocal for the exact truncating divide by CALIB_SAMPLES
    localparam int RECIP_SH = SUM_W + CNT_W;
    localparam logic [RECIP_SH:0] RECIP = (RECIP_SH + 1)'(
        ((64'd1 << RECIP_SH) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

    // bus geometry
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;

    // register reset values
    localparam logic [DIST_W-1:0]  THRESHOLD_RST     = DIST_W'(10000);
    localparam logic [DWELL_W-1:0] OCC_SAMPLES_RST   = DWELL_W'(5);
    localparam logic [DWELL_W-1:0] EMPTY_SAMPLES_RST = DWELL_W'(5);

    typedef enum logic [1:0] {
        REG_THRESHOLD     = 2'd0,
        REG_OCC_SAMPLES   = 2'd1,
        REG_EMPTY_SAMPLES = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_EMPTY    = 2'd0,
        PH_TO_OCC   = 2'd1,
        PH_OCC      = 2'd2,
        PH_TO_EMPTY = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_OCCUPIED = 2'd1,
        EV_EMPTY    = 2'd2
    } event_t;

    typedef logic [NUM_AXES-1:0][SAMPLE_W-1:0] axes_t;

    typedef struct packed {
        logic                          calibrating;
        logic [NUM_AXES-1:0][SQ_W-1:0] sq;
    } sq_stage_t;

    typedef struct packed {
        logic              calibrating;
        logic              occupied_flag;
        event_t            event_code;
        logic [DIST_W-1:0] squared_distance;
    } result_t;

    // signed sum / CALIB_SAMPLES, truncated toward zero
    function automatic logic [SAMPLE_W-1:0] div_trunc(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0]          mag;
        logic [SUM_W+RECIP_SH:0]   prod;
        logic [SAMPLE_W-1:0]       quo;
        mag  = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
        prod = {{(RECIP_SH + 1){1'b0}}, mag} * {{SUM_W{1'b0}}, RECIP};
        quo  = prod[RECIP_SH +: SAMPLE_W];
        return sum[SUM_W-1] ? (~quo + SAMPLE_W'(1)) : quo;
    endfunction

endpackage

`default_nettype wire

### sv/magnetic_occupancy_detector.sv
`default_nettype none
// m_tvalid rises once the accepted item is through the input, square and result stage registers
// one transaction per cycle while m_tready is high, set by the three-stage pipeline with per-stage ready
// each stage holds its item under output backpressure, bubbles still fill upstream
// reset: aresetn synchronous active low, clears stage valids, debounce, calibration
// and restores register defaults (threshold 10000, dwell 5 and 5)

module magnetic_occupancy_detector
    import mag_occ_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // sample channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // field_x, field_y, field_z

    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // occupied_flag, event_code, squared_distance, pad
    output logic [0:0]                m_tuser,   // calibrating

    // register port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    // configuration registers
    logic [DIST_W-1:0]  threshold_reg;
    logic [DWELL_W-1:0] occ_samples_reg;
    logic [DWELL_W-1:0] empty_samples_reg;
    reg_idx_t           reg_idx;
    logic               reg_write;

    // pipeline control
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic accept;
    logic load2;
    logic load3;

    axes_t     sample;
    axes_t     baseline;
    logic      calibrating;
    sq_stage_t sq_stage;
    result_t   result;

    // register access, 8-byte stride since the threshold is 34 bits
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg     <= THRESHOLD_RST;
            occ_samples_reg   <= OCC_SAMPLES_RST;
            empty_samples_reg <= EMPTY_SAMPLES_RST;
        end else if (reg_write) begin
            case (reg_idx)
                REG_THRESHOLD:     threshold_reg     <= pwdata[DIST_W-1:0];
                REG_OCC_SAMPLES:   occ_samples_reg   <= pwdata[DWELL_W-1:0];
                REG_EMPTY_SAMPLES: empty_samples_reg <= pwdata[DWELL_W-1:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD:     prdata = DATA_W'(threshold_reg);
            REG_OCC_SAMPLES:   prdata = DATA_W'(occ_samples_reg);
            REG_EMPTY_SAMPLES: prdata = DATA_W'(empty_samples_reg);
            default:           prdata = '0;
        endcase
    end

    // per-stage ready: a stage takes a new item when it is empty or the next one moves
    assign s3_ready = !s3_valid_reg || m_tready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;

    assign accept = s_tvalid && s1_ready;
    assign load2  = s1_valid_reg && s2_ready;
    assign load3  = s2_valid_reg && s3_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (load2) begin
                s1_valid_reg <= 1'b0;
            end
            if (load2) begin
                s2_valid_reg <= 1'b1;
            end else if (load3) begin
                s2_valid_reg <= 1'b0;
            end
            if (load3) begin
                s3_valid_reg <= 1'b1;
            end else if (m_tready) begin
                s3_valid_reg <= 1'b0;
            end
        end
    end

    // unpack the sample, x in the low bits
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            sample[i] = s_tdata[i*SAMPLE_W +: SAMPLE_W];
        end
    end

    // calibration runs at acceptance so the baseline is ready before the next sample squares
    mag_occ_calib u_calib (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .sample      (sample),
        .calibrating (calibrating),
        .baseline    (baseline)
    );

    // input register and per-axis squared difference
    mag_occ_square u_square (
        .aclk        (aclk),
        .accept      (accept),
        .sample      (sample),
        .calibrating (calibrating),
        .load        (load2),
        .baseline    (baseline),
        .sq_stage    (sq_stage)
    );

    // distance sum, threshold compare, debounce and result register
    mag_occ_debounce u_debounce (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load3),
        .sq_stage      (sq_stage),
        .threshold     (threshold_reg),
        .occ_samples   (occ_samples_reg),
        .empty_samples (empty_samples_reg),
        .result        (result)
    );

    assign m_tvalid = s3_valid_reg;
    assign m_tuser  = result.calibrating;
    assign m_tdata  = {3'b000, result.squared_distance, result.event_code,
                       result.occupied_flag};

endmodule

`default_nettype wire

### sv/mag_occ_calib.sv
`default_nettype none

module mag_occ_calib
    import mag_occ_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  accept,
    input  wire axes_t sample,
    output logic       calibrating,
    output axes_t      baseline
);

    logic                          cal_reg;
    logic                          load_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [NUM_AXES-1:0][SUM_W-1:0] sums_reg;
    logic [NUM_AXES-1:0][SUM_W-1:0] sums_next;
    axes_t                         baseline_reg;
    axes_t                         baseline_next;
    logic                          take;
    logic                          done;

    assign take       = accept && cal_reg;
    assign count_next = count_reg + CNT_W'(1);
    assign done       = (count_next == CNT_W'(CALIB_SAMPLES));

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            sums_next[i]     = sums_reg[i] + {{CNT_W{sample[i][SAMPLE_W-1]}}, sample[i]};
            baseline_next[i] = div_trunc(sums_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg      <= 1'b1;
            load_reg     <= 1'b0;
            count_reg    <= '0;
            sums_reg     <= '0;
            baseline_reg <= '0;
        end else begin
            load_reg <= take && done;
            if (take) begin
                sums_reg  <= sums_next;
                count_reg <= count_next;
                if (done) begin
                    cal_reg <= 1'b0;
                end
            end
            // load_reg marks that the sums hold the last calibration sample
            if (load_reg) begin
                baseline_reg <= baseline_next;
            end
        end
    end

    assign calibrating = cal_reg;
    assign baseline    = baseline_reg;

    a_load_after_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(cal_reg) |-> load_reg)
        else $error("baseline load missing at end of calibration");

    a_count_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !cal_reg |-> (count_reg == CNT_W'(CALIB_SAMPLES)))
        else $error("calibration ended with wrong sample count");

endmodule

`default_nettype wire

### sv/mag_occ_square.sv
`default_nettype none

module mag_occ_square
    import mag_occ_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  accept,
    input  wire axes_t sample,
    input  wire logic  calibrating,
    input  wire logic  load,
    input  wire axes_t baseline,
    output sq_stage_t  sq_stage
);

    axes_t                        sample_reg;
    logic                         cal_reg;
    logic signed [SAMPLE_W:0]     diff [NUM_AXES];
    logic signed [2*SAMPLE_W+1:0] prod [NUM_AXES];
    sq_stage_t                    stage_reg;
    sq_stage_t                    stage_next;

    always_comb begin
        stage_next.calibrating = cal_reg;
        for (int i = 0; i < NUM_AXES; i++) begin
            diff[i] = $signed({sample_reg[i][SAMPLE_W-1], sample_reg[i]})
                    - $signed({baseline[i][SAMPLE_W-1], baseline[i]});
            prod[i] = diff[i] * diff[i];
            stage_next.sq[i] = prod[i][SQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= sample;
            cal_reg    <= calibrating;
        end
        if (load) begin
            stage_reg <= stage_next;
        end
    end

    assign sq_stage = stage_reg;

endmodule

`default_nettype wire

### sv/mag_occ_debounce.sv
`default_nettype none

module mag_occ_debounce
    import mag_occ_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire sq_stage_t          sq_stage,
    input  wire logic [DIST_W-1:0]  threshold,
    input  wire logic [DWELL_W-1:0] occ_samples,
    input  wire logic [DWELL_W-1:0] empty_samples,
    output result_t                 result
);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [DWELL_W-1:0]  dwell_reg;
    logic [DWELL_W-1:0]  dwell_next;
    logic [DIST_W-1:0]   distance;
    logic                above;
    logic                below;
    logic                occ;
    logic                step;
    event_t              ev;
    result_t             res_reg;
    result_t             res_next;

    // dwell left after the first qualifying sample, zero counts as one
    function automatic logic [DWELL_W-1:0] first_dwell(input logic [DWELL_W-1:0] r);
        return (r <= DWELL_W'(1)) ? '0 : r - DWELL_W'(1);
    endfunction

    assign distance = DIST_W'(sq_stage.sq[0]) + DIST_W'(sq_stage.sq[1])
                    + DIST_W'(sq_stage.sq[2]);
    assign above = distance > threshold;
    assign below = distance < threshold;
    assign occ   = (phase_reg == PH_OCC) || (phase_reg == PH_TO_EMPTY);
    assign step  = load && !sq_stage.calibrating;

    always_comb begin
        phase_next = phase_reg;
        dwell_next = dwell_reg;
        ev         = EV_NONE;
        if (step) begin
            case (phase_reg)
                PH_TO_OCC: begin
                    if (above) begin
                        if (dwell_reg <= DWELL_W'(1)) begin
                            dwell_next = '0;
                            phase_next = PH_OCC;
                            ev         = EV_OCCUPIED;
                        end else begin
                            dwell_next = dwell_reg - DWELL_W'(1);
                        end
                    end else begin
                        phase_next = PH_EMPTY;
                    end
                end
                PH_OCC: begin
                    if (below) begin
                        dwell_next = first_dwell(empty_samples);
                        if (first_dwell(empty_samples) == '0) begin
                            phase_next = PH_EMPTY;
                            ev         = EV_EMPTY;
                        end else begin
                            phase_next = PH_TO_EMPTY;
                        end
                    end
                end
                PH_TO_EMPTY: begin
                    if (below) begin
                        if (dwell_reg <= DWELL_W'(1)) begin
                            dwell_next = '0;
                            phase_next = PH_EMPTY;
                            ev         = EV_EMPTY;
                        end else begin
                            dwell_next = dwell_reg - DWELL_W'(1);
                        end
                    end else begin
                        phase_next = PH_OCC;
                    end
                end
                default: begin
                    if (above) begin
                        dwell_next = first_dwell(occ_samples);
                        if (first_dwell(occ_samples) == '0) begin
                            phase_next = PH_OCC;
                            ev         = EV_OCCUPIED;
                        end else begin
                            phase_next = PH_TO_OCC;
                        end
                    end else begin
                        phase_next = PH_EMPTY;
                    end
                end
            endcase
        end

        res_next.calibrating      = sq_stage.calibrating;
        res_next.occupied_flag    = sq_stage.calibrating ? 1'b0 : occ;
        res_next.event_code       = ev;
        res_next.squared_distance = sq_stage.calibrating ? '0 : distance;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_EMPTY;
            dwell_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            dwell_reg <= dwell_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

    a_occ_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && ev == EV_OCCUPIED) |=> (phase_reg == PH_OCC))
        else $error("occupied event without occupied phase");

    a_empty_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && ev == EV_EMPTY) |=> (phase_reg == PH_EMPTY))
        else $error("empty event without empty phase");

    a_pending_dwell: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TO_OCC || phase_reg == PH_TO_EMPTY) |-> (dwell_reg != '0))
        else $error("pending phase with exhausted dwell");

    a_hold_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(phase_reg))
        else $error("phase moved without a sample");

endmodule

`default_nettype wire

### bench/occupancy_checker.sv
module occupancy_checker
    import mag_occ_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // field_x, field_y, field_z
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,   // occupied_flag, event_code, squared_distance, pad
    input  wire logic [0:0]           m_tuser,   // calibrating
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    input  wire logic                 pready,
    output int                        mismatches,
    output int                        pending_count
);

    typedef enum logic [2:0] {
        DET_CALIBRATING,
        DET_EMPTY,
        DET_ARMING,
        DET_OCCUPIED,
        DET_CLEARING
    } det_phase_t;

    // register copies
    logic [DIST_W-1:0]  thr_reg;
    logic [DWELL_W-1:0] occ_dwell_reg;
    logic [DWELL_W-1:0] emp_dwell_reg;

    // detector state
    det_phase_t         det_phase;
    logic [5:0]         calib_taken;
    int                 axis_acc[NUM_AXES];
    int                 base_level[NUM_AXES];
    logic [DWELL_W-1:0] dwell_left;

    result_t            pending_reports[$];
    int                 fail_total = 0;
    int                 result_index = 0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("result %0d %s: got %0d expected %0d", result_index, what, got, want);
        fail_total++;
    endtask

    function automatic result_t predict_report(input logic [S_TDATA_W-1:0] data);
        result_t           rpt;
        longint            diff;
        logic [63:0]       acc64;
        logic [DIST_W-1:0] distance;
        logic              above;
        logic              below;
        rpt = '0;
        rpt.event_code = EV_NONE;
        if (det_phase == DET_CALIBRATING) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                axis_acc[i] += int'($signed(data[SAMPLE_W*i +: SAMPLE_W]));
            end
            calib_taken = calib_taken + 6'd1;
            if (calib_taken >= CALIB_SAMPLES) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    base_level[i] = axis_acc[i] / CALIB_SAMPLES;
                end
                det_phase = DET_EMPTY;
            end
            rpt.calibrating = 1'b1;
            return rpt;
        end

        acc64 = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            diff  = longint'($signed(data[SAMPLE_W*i +: SAMPLE_W])) - longint'(base_level[i]);
            acc64 += 64'(diff * diff);
        end
        distance = acc64[DIST_W-1:0];
        above    = distance > thr_reg;
        below    = distance < thr_reg;
        rpt.occupied_flag    = (det_phase == DET_OCCUPIED) || (det_phase == DET_CLEARING);
        rpt.squared_distance = distance;

        case (det_phase)
            DET_ARMING: begin
                if (above) begin
                    if (dwell_left <= 1) begin
                        dwell_left     = '0;
                        det_phase      = DET_OCCUPIED;
                        rpt.event_code = EV_OCCUPIED;
                    end else begin
                        dwell_left = dwell_left - 1'b1;
                    end
                end else begin
                    det_phase = DET_EMPTY;
                end
            end
            DET_OCCUPIED: begin
                if (below) begin
                    dwell_left = (emp_dwell_reg <= 1) ? '0 : emp_dwell_reg - 1'b1;
                    if (dwell_left == 0) begin
                        det_phase      = DET_EMPTY;
                        rpt.event_code = EV_EMPTY;
                    end else begin
                        det_phase = DET_CLEARING;
                    end
                end
            end
            DET_CLEARING: begin
                if (below) begin
                    if (dwell_left <= 1) begin
                        dwell_left     = '0;
                        det_phase      = DET_EMPTY;
                        rpt.event_code = EV_EMPTY;
                    end else begin
                        dwell_left = dwell_left - 1'b1;
                    end
                end else begin
                    det_phase = DET_OCCUPIED;
                end
            end
            default: begin
                if (above) begin
                    dwell_left = (occ_dwell_reg <= 1) ? '0 : occ_dwell_reg - 1'b1;
                    if (dwell_left == 0) begin
                        det_phase      = DET_OCCUPIED;
                        rpt.event_code = EV_OCCUPIED;
                    end else begin
                        det_phase = DET_ARMING;
                    end
                end else begin
                    det_phase = DET_EMPTY;
                end
            end
        endcase
        return rpt;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            thr_reg       = THRESHOLD_RST;
            occ_dwell_reg = OCC_SAMPLES_RST;
            emp_dwell_reg = EMPTY_SAMPLES_RST;
            det_phase     = DET_CALIBRATING;
            calib_taken   = '0;
            dwell_left    = '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                axis_acc[i]   = 0;
                base_level[i] = 0;
            end
            pending_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[ADDR_W-1:3]))
                    REG_THRESHOLD:     thr_reg       = pwdata[DIST_W-1:0];
                    REG_OCC_SAMPLES:   occ_dwell_reg = pwdata[DWELL_W-1:0];
                    REG_EMPTY_SAMPLES: emp_dwell_reg = pwdata[DWELL_W-1:0];
                    default: ;
                endcase
            end

            // compare before queuing: a result never belongs to the sample of the same edge
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch("with no sample outstanding", m_tdata, 0);
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tuser[0] !== want.calibrating)
                        report_mismatch("calibrating", m_tuser[0], want.calibrating);
                    if (m_tdata[0] !== want.occupied_flag)
                        report_mismatch("occupied_flag", m_tdata[0], want.occupied_flag);
                    if (m_tdata[2:1] !== want.event_code)
                        report_mismatch("event_code", m_tdata[2:1], want.event_code);
                    if (m_tdata[3 +: DIST_W] !== want.squared_distance)
                        report_mismatch("squared_distance", m_tdata[3 +: DIST_W],
                                        want.squared_distance);
                end
                result_index++;
            end

            if (s_tvalid && s_tready)
                pending_reports.push_back(predict_report(s_tdata));
        end
        mismatches    <= fail_total;
        pending_count <= pending_reports.size();
    end

endmodule

### bench/magnetic_occupancy_detector_tb.sv
module magnetic_occupancy_detector_tb;
    import mag_occ_pkg::*;

    // an idle count past this limit, with no accepted transaction on either channel, ends the run
    localparam int         WATCHDOG_LIMIT = 2000;
    // largest offset from the baseline that always stays inside a 16-bit sample
    localparam longint     AXIS_SPAN      = 32767;
    localparam logic [1:0] UNMAPPED_IDX   = 2'd3;
    localparam logic [DIST_W-1:0] THR_MAX = '1;

    typedef enum {
        SHAPE_QUIET,   // strictly below the threshold, or the baseline at a zero threshold
        SHAPE_LOUD,    // strictly above the threshold when reachable, else the farthest corner
        SHAPE_EDGE,    // exactly on the threshold where it is a perfect square
        SHAPE_STILL,   // the baseline itself
        SHAPE_FAR,     // farthest corner from the baseline
        SHAPE_NOISE    // anything at all
    } shape_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_LONG} rx_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // field_x, field_y, field_z
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // occupied_flag, event_code, squared_distance, pad
    logic [0:0]           m_tuser;         // calibrating
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [DATA_W-1:0]    pwdata   = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int mismatches;
    int pending_count;

    // stimulus-side view of the block: current registers and the learned baseline
    logic [DIST_W-1:0]  thr_now = THRESHOLD_RST;
    logic [DWELL_W-1:0] occ_now = OCC_SAMPLES_RST;
    logic [DWELL_W-1:0] emp_now = EMPTY_SAMPLES_RST;
    int                 base_lvl[NUM_AXES];

    // sender burst shaping
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // receiver stall pattern
    rx_mode_t rx_mode  = RX_OPEN;
    int       rx_cycle = 0;
    int       rx_hold  = 0;

    int idle_cycles = 0;

    always #2 aclk = ~aclk;

    magnetic_occupancy_detector u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    occupancy_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .pending_count (pending_count)
    );

    // receiver: rx_cycle picks when the stall style is drawn anew, one style never stalls
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                // long stalls now and then
                if (rx_hold > 0) begin
                    m_tready <= 1'b0;
                    rx_hold  <= rx_hold - 1;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 9) == 0)
                        rx_hold <= $urandom_range(1, 12);
                end
            end
        endcase
    end

    // watchdog: a hung pipeline or a lost result stops the run here
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic longint isqrt(input longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 131072;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // builds a sample at a chosen squared distance from the baseline; each offset points
    // toward zero so the sample never leaves the 16-bit range
    function automatic logic [S_TDATA_W-1:0] shaped_sample(input shape_t shape);
        longint               off[NUM_AXES];
        longint               a;
        longint               span;
        longint               thr;
        longint               v;
        logic [S_TDATA_W-1:0] word;
        bit                   far;
        thr  = longint'(thr_now);
        far  = 1'b0;
        word = '0;
        for (int i = 0; i < NUM_AXES; i++) off[i] = 0;
        case (shape)
            SHAPE_NOISE: begin
                word = S_TDATA_W'({$urandom(), $urandom()});
                return word;
            end
            SHAPE_QUIET: begin
                // zero threshold: nothing is below, the baseline is the closest we get
                if (thr > 0) begin
                    a = isqrt((thr - 1) / 3);
                    if (a > AXIS_SPAN) a = AXIS_SPAN;
                    for (int i = 0; i < NUM_AXES; i++) off[i] = $urandom_range(0, a);
                end
            end
            SHAPE_EDGE: begin
                a = isqrt(thr);
                if (a * a == thr && a <= AXIS_SPAN)
                    off[$urandom_range(0, NUM_AXES - 1)] = a;
            end
            SHAPE_LOUD: begin
                a = isqrt(thr) + 1;
                if (a <= AXIS_SPAN) begin
                    // half the time just over the line, else anywhere above it
                    span = AXIS_SPAN - a;
                    if ($urandom_range(0, 1) && span > 3) span = 3;
                    off[$urandom_range(0, NUM_AXES - 1)] = a + $urandom_range(0, span);
                end else begin
                    a = isqrt(thr / 3) + 1;
                    if (a <= AXIS_SPAN) begin
                        for (int i = 0; i < NUM_AXES; i++) off[i] = a;
                    end else begin
                        far = 1'b1;
                    end
                end
            end
            SHAPE_FAR:   far = 1'b1;
            default: ;
        endcase
        for (int i = 0; i < NUM_AXES; i++) begin
            if (far)
                v = (base_lvl[i] >= 0) ? -32768 : 32767;
            else
                v = (base_lvl[i] >= 0) ? base_lvl[i] - off[i] : base_lvl[i] + off[i];
            word[SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'(v);
        end
        return word;
    endfunction

    // run length around a dwell setting: one short, exact, or one long, capped for huge dwells
    function automatic int run_len(input logic [DWELL_W-1:0] dwell);
        int len;
        len = (dwell <= 1) ? 1 : ((dwell > 12) ? 12 : int'(dwell));
        len = len + $urandom_range(0, 2) - 1;
        return (len < 1) ? 1 : len;
    endfunction

    // one sample transaction; called right after a rising edge, returns at its accepting edge
    task automatic push_sample(input logic [S_TDATA_W-1:0] word);
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic push_shape(input shape_t shape, input int count);
        repeat (count) push_sample(shaped_sample(shape));
    endtask

    // setup and access phase, then idle with psel low so back-to-back writes stay clean
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // drain: every result back, then idle before the next step
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic apply_settings(input logic [DIST_W-1:0] thr, input logic [DWELL_W-1:0] occ,
                                  input logic [DWELL_W-1:0] emp);
        settle();
        apb_write({REG_THRESHOLD, 3'b000}, DATA_W'(thr));
        apb_write({REG_OCC_SAMPLES, 3'b000}, DATA_W'(occ));
        apb_write({REG_EMPTY_SAMPLES, 3'b000}, DATA_W'(emp));
        thr_now = thr;
        occ_now = occ;
        emp_now = emp;
        gaps_on = ($urandom_range(0, 3) != 0);
    endtask

    // mostly full occupy/vacate cycles of random content, else noise, lone samples, broken runs
    task automatic run_phase(input int item_goal);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < item_goal) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len = run_len(occ_now);
                push_shape(SHAPE_LOUD, len);
                sent += len;
                if ($urandom_range(0, 3) == 0) begin
                    push_shape(SHAPE_EDGE, 1);
                    sent++;
                end
                len = run_len(emp_now);
                push_shape(SHAPE_QUIET, len);
                sent += len;
            end else if (pick == 7) begin
                len = $urandom_range(1, 3);
                push_shape(SHAPE_NOISE, len);
                sent += len;
            end else if (pick == 8) begin
                push_shape(($urandom_range(0, 1) != 0) ? SHAPE_EDGE : SHAPE_STILL, 1);
                sent++;
            end else begin
                // arming or clearing cut short
                len = $urandom_range(1, 4);
                push_shape(SHAPE_LOUD, len);
                push_shape(SHAPE_QUIET, 1);
                push_shape(SHAPE_LOUD, 1);
                sent += len + 2;
            end
        end
    endtask

    initial begin : stimulus
        int                   sums[NUM_AXES];
        int                   center[NUM_AXES];
        int                   v;
        logic [S_TDATA_W-1:0] word;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // calibration: one sample at each field extreme, the rest scattered around a center;
        // x sits below zero and y above so both signs of the truncating divide are seen
        center[0] = -int'($urandom_range(1, 20000));
        center[1] = int'($urandom_range(1, 20000));
        center[2] = int'($urandom_range(0, 40000)) - 20000;
        for (int i = 0; i < NUM_AXES; i++) sums[i] = 0;
        for (int k = 0; k < CALIB_SAMPLES; k++) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                if (k == 0)
                    v = -32768;
                else if (k == 1)
                    v = 32767;
                else
                    v = center[i] + int'($urandom_range(0, 100)) - 50;
                sums[i] += v;
                word[SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'(v);
            end
            push_sample(word);
        end
        for (int i = 0; i < NUM_AXES; i++) base_lvl[i] = sums[i] / CALIB_SAMPLES;

        // directed debounce walk under the reset settings
        push_shape(SHAPE_EDGE, 1);                 // on the threshold: neither side
        push_shape(SHAPE_LOUD, 5);                 // full arming run, occupied event
        push_shape(SHAPE_FAR, 1);                  // largest distance while occupied
        push_shape(SHAPE_EDGE, 1);
        push_shape(SHAPE_QUIET, 3);                // clearing interrupted
        push_shape(SHAPE_LOUD, 1);
        push_shape(SHAPE_QUIET, 5);                // full clearing run, empty event
        push_shape(SHAPE_LOUD, 2);                 // arming interrupted
        push_shape(SHAPE_QUIET, 1);
        push_shape(SHAPE_STILL, 1);                // zero distance
        push_sample({NUM_AXES{16'h8000}});         // most negative sample
        push_sample({NUM_AXES{16'h7FFF}});         // most positive sample

        // zero threshold with a zero occupied dwell: first loud sample occupies at once
        apply_settings('0, '0, 16'd1);
        run_phase(100);

        // largest threshold and dwells: nothing can ever be above
        apply_settings(THR_MAX, '1, '1);
        run_phase(60);

        // arming that never completes, clearing on a single sample
        apply_settings(DIST_W'(10000), '1, 16'd1);
        run_phase(60);

        // smallest nonzero threshold, plus a write past the register map that must be ignored
        apply_settings(DIST_W'(1), 16'd1, 16'd2);
        apb_write({UNMAPPED_IDX, 3'b000}, {$urandom(), $urandom()});
        run_phase(100);

        repeat (10) begin
            v = $urandom_range(1, 4000);
            apply_settings(($urandom_range(0, 4) == 0) ?
                               DIST_W'({$urandom_range(0, 3), $urandom()}) : DIST_W'(v * v),
                           ($urandom_range(0, 7) == 0) ? '0 : DWELL_W'($urandom_range(1, 8)),
                           ($urandom_range(0, 7) == 0) ? '0 : DWELL_W'($urandom_range(1, 8)));
            run_phase(90);
        end

        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
sv/mag_occ_pkg.sv
sv/mag_occ_calib.sv
sv/mag_occ_square.sv
sv/mag_occ_debounce.sv
sv/magnetic_occupancy_detector.sv
bench/occupancy_checker.sv
bench/magnetic_occupancy_detector_tb.sv
